// File: sv/pgrc_pkg.sv
package pgrc_pkg;

    localparam int PosW   = 32;
    localparam int QuatW  = 16;
    localparam int DistW  = 33;
    localparam int YawW   = 15;
    localparam int SqW    = 67;
    localparam int ProdW  = 34;
    localparam int MagW   = 33;
    localparam int NormW  = 21;
    localparam int CorW   = 46;
    localparam int AngW   = 28;
    localparam int Steps  = 24;

    localparam int DistLat = 36;
    localparam int YawLat  = 32;

    localparam logic [DistW-1:0] PosTolReset = 33'd6554;
    localparam logic [YawW-1:0]  YawTolReset = 15'd819;
    localparam logic [YawW-1:0]  YawMax      = 15'd25736;
    localparam logic signed [AngW-1:0] HalfPi = 28'sd26353589;

    localparam logic [3:0] AddrPosTol = 4'd0;
    localparam logic [3:0] AddrYawTol = 4'd8;

    function automatic logic signed [AngW-1:0] atan_lut(input int i);
        logic signed [AngW-1:0] v;
        case (i)
            0:  v = 28'sd13176795;
            1:  v = 28'sd7778716;
            2:  v = 28'sd4110060;
            3:  v = 28'sd2086331;
            4:  v = 28'sd1047214;
            5:  v = 28'sd524117;
            6:  v = 28'sd262123;
            7:  v = 28'sd131069;
            default: v = AngW'(28'sd2 <<< (23 - i));
        endcase
        return v;
    endfunction

endpackage

// File: sv/pose_goal_reached_check.sv
// Channel  | Ports                                   | Transfer
// ---------+-----------------------------------------+--------------------------
// input    | start, busy, i_goal_*, i_current_*      | start high, busy low
// result   | o_valid, o_distance_error, o_yaw_error, | o_valid high, one cycle
//          | o_reached                               |
// config   | psel penable pwrite paddr pwdata prdata | psel&penable&pwrite
//
// One pose pair per cycle; the 33-stage square root of the distance path sets
// when each result appears after its input transfer.
// busy is always low. Reset (synchronous, active low) clears the pipeline
// valid bits and loads the tolerance defaults. Results cannot be held off.
module pose_goal_reached_check
    import pgrc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [PosW-1:0]  i_goal_x,
    input  logic signed [PosW-1:0]  i_goal_y,
    input  logic signed [QuatW-1:0] i_goal_qw,
    input  logic signed [QuatW-1:0] i_goal_qx,
    input  logic signed [QuatW-1:0] i_goal_qy,
    input  logic signed [QuatW-1:0] i_goal_qz,
    input  logic signed [PosW-1:0]  i_current_x,
    input  logic signed [PosW-1:0]  i_current_y,
    input  logic signed [QuatW-1:0] i_current_qw,
    input  logic signed [QuatW-1:0] i_current_qx,
    input  logic signed [QuatW-1:0] i_current_qy,
    input  logic signed [QuatW-1:0] i_current_qz,
    output logic                    o_valid,
    output logic [DistW-1:0]        o_distance_error,
    output logic [YawW-1:0]         o_yaw_error,
    output logic                    o_reached,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [63:0]             pwdata,
    output logic [63:0]             prdata,
    output logic                    pready
);

    localparam int Dly = DistLat - YawLat;

    logic [DistW-1:0]        r_pos_tol;
    logic [YawW-1:0]         r_yaw_tol;
    logic                    n_in;
    logic signed [QuatW-1:0] n_gq [0:3];
    logic signed [QuatW-1:0] n_cq [0:3];
    logic                    w_qv, w_yv, w_dv;
    logic signed [CorW-1:0]  w_x, w_y;
    logic [YawW-1:0]         w_yaw;
    logic [DistW-1:0]        w_dist;
    logic [YawW-1:0]         r_yd [0:Dly-1];

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign n_in   = start && !busy;
    assign prdata = paddr[3] ? 64'(r_yaw_tol) : 64'(r_pos_tol);

    assign n_gq[0] = i_goal_qw;
    assign n_gq[1] = i_goal_qx;
    assign n_gq[2] = i_goal_qy;
    assign n_gq[3] = i_goal_qz;
    assign n_cq[0] = i_current_qw;
    assign n_cq[1] = i_current_qx;
    assign n_cq[2] = i_current_qy;
    assign n_cq[3] = i_current_qz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_tol <= PosTolReset;
            r_yaw_tol <= YawTolReset;
        end else if (psel && penable && pwrite) begin
            if (paddr[3] == AddrYawTol[3]) begin
                r_yaw_tol <= pwdata[YawW-1:0];
            end else begin
                r_pos_tol <= pwdata[DistW-1:0];
            end
        end
    end

    pgrc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (n_in),
        .i_gx    (i_goal_x),
        .i_gy    (i_goal_y),
        .i_cx    (i_current_x),
        .i_cy    (i_current_y),
        .o_vld   (w_dv),
        .o_dist  (w_dist)
    );

    pgrc_quat u_quat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (n_in),
        .i_gq    (n_gq),
        .i_cq    (n_cq),
        .o_vld   (w_qv),
        .o_x     (w_x),
        .o_y     (w_y)
    );

    pgrc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_qv),
        .i_x     (w_x),
        .i_y     (w_y),
        .o_vld   (w_yv),
        .o_yaw   (w_yaw)
    );

    always_ff @(posedge i_clk) begin
        r_yd[0] <= w_yaw;
        for (int i = 1; i < Dly; i++) begin
            r_yd[i] <= r_yd[i-1];
        end
        o_distance_error <= w_dist;
        o_yaw_error      <= r_yd[Dly-1];
        o_reached        <= (w_dist < r_pos_tol) && (r_yd[Dly-1] < r_yaw_tol);
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_dv;
        end
    end

endmodule

// File: sv/pgrc_dist.sv
module pgrc_dist
    import pgrc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic signed [PosW-1:0]  i_gx,
    input  logic signed [PosW-1:0]  i_gy,
    input  logic signed [PosW-1:0]  i_cx,
    input  logic signed [PosW-1:0]  i_cy,
    output logic                    o_vld,
    output logic [DistW-1:0]        o_dist
);

    logic [MagW-1:0]   r_ax, r_ay;
    logic [2*MagW-1:0] r_sx, r_sy;
    logic [1:0]        r_v;
    logic [SqW-1:0]    r_rem  [0:DistW];
    logic [DistW-1:0]  r_root [0:DistW];
    logic [DistW:0]    r_sv;
    logic signed [MagW-1:0] n_dx, n_dy;

    assign n_dx = MagW'(i_gx) - MagW'(i_cx);
    assign n_dy = MagW'(i_gy) - MagW'(i_cy);

    always_ff @(posedge i_clk) begin
        r_ax      <= n_dx[MagW-1] ? MagW'(-n_dx) : MagW'(n_dx);
        r_ay      <= n_dy[MagW-1] ? MagW'(-n_dy) : MagW'(n_dy);
        r_sx      <= r_ax * r_ax;
        r_sy      <= r_ay * r_ay;
        r_rem[0]  <= SqW'(r_sx) + SqW'(r_sy);
        r_root[0] <= '0;
        if (!i_rst_n) begin
            r_v     <= '0;
            r_sv[0] <= 1'b0;
        end else begin
            r_v     <= {r_v[0], i_vld};
            r_sv[0] <= r_v[1];
        end
    end

    for (genvar s = 0; s < DistW; s++) begin : g_sq
        localparam int B = DistW - 1 - s;
        logic [SqW-1:0] n_term;
        assign n_term = (SqW'(r_root[s]) << (B + 1)) + (SqW'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if (r_rem[s] >= n_term) begin
                r_rem[s+1]  <= r_rem[s] - n_term;
                r_root[s+1] <= r_root[s] | (DistW'(1) << B);
            end else begin
                r_rem[s+1]  <= r_rem[s];
                r_root[s+1] <= r_root[s];
            end
            if (!i_rst_n) begin
                r_sv[s+1] <= 1'b0;
            end else begin
                r_sv[s+1] <= r_sv[s];
            end
        end
    end

    assign o_vld  = r_sv[DistW];
    assign o_dist = r_root[DistW];

endmodule

// File: sv/pgrc_quat.sv
module pgrc_quat
    import pgrc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic signed [QuatW-1:0]   i_gq [0:3],
    input  logic signed [QuatW-1:0]   i_cq [0:3],
    output logic                      o_vld,
    output logic signed [CorW-1:0]    o_x,
    output logic signed [CorW-1:0]    o_y
);

    logic signed [2*QuatW-1:0] r_pr [0:3][0:3];
    logic signed [ProdW-1:0]   r_p  [0:3];
    logic [MagW-1:0]           r_a  [0:3];
    logic [3:0]                r_sg;
    logic signed [NormW-1:0]   r_n  [0:3];
    logic signed [2*NormW-1:0] r_ww, r_xx, r_yy, r_zz, r_wz, r_xy;
    logic signed [CorW-1:0]    r_x, r_y;
    logic [5:0]                r_v;
    logic [MagW-1:0]           n_or;
    logic [5:0]                n_k;

    function automatic logic signed [ProdW-1:0] ex(input logic signed [2*QuatW-1:0] v);
        return ProdW'(v);
    endfunction

    always_comb begin
        n_or = r_a[0] | r_a[1] | r_a[2] | r_a[3];
        n_k  = 6'd19;
        for (int b = 0; b < MagW; b++) begin
            if (n_or[b]) n_k = 6'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < 4; g++) begin
            for (int c = 0; c < 4; c++) begin
                r_pr[g][c] <= i_gq[g] * i_cq[c];
            end
        end
        r_p[0] <= ex(r_pr[0][0]) + ex(r_pr[1][1]) + ex(r_pr[2][2]) + ex(r_pr[3][3]);
        r_p[1] <= -ex(r_pr[0][1]) + ex(r_pr[1][0]) - ex(r_pr[2][3]) + ex(r_pr[3][2]);
        r_p[2] <= -ex(r_pr[0][2]) + ex(r_pr[1][3]) + ex(r_pr[2][0]) - ex(r_pr[3][1]);
        r_p[3] <= -ex(r_pr[0][3]) - ex(r_pr[1][2]) + ex(r_pr[2][1]) + ex(r_pr[3][0]);
        for (int i = 0; i < 4; i++) begin
            r_a[i]  <= r_p[i][ProdW-1] ? MagW'(-r_p[i]) : MagW'(r_p[i]);
            r_sg[i] <= r_p[i][ProdW-1];
        end
        for (int i = 0; i < 4; i++) begin
            logic [MagW+19:0] t;
            if (n_k >= 6'd20) begin
                t = (MagW+20)'(r_a[i] >> (n_k - 6'd19));
            end else begin
                t = (MagW+20)'(r_a[i]) << (6'd19 - n_k);
            end
            r_n[i] <= r_sg[i] ? -NormW'(t[NormW-2:0]) : NormW'(t[NormW-2:0]);
        end
        r_ww <= r_n[0] * r_n[0];
        r_xx <= r_n[1] * r_n[1];
        r_yy <= r_n[2] * r_n[2];
        r_zz <= r_n[3] * r_n[3];
        r_wz <= r_n[0] * r_n[3];
        r_xy <= r_n[1] * r_n[2];
        r_x  <= CorW'(r_ww) + CorW'(r_xx) - CorW'(r_yy) - CorW'(r_zz);
        r_y  <= (CorW'(r_wz) + CorW'(r_xy)) <<< 1;
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:0], i_vld};
        end
    end

    assign o_vld = r_v[5];
    assign o_x   = r_x;
    assign o_y   = r_y;

endmodule

// File: sv/pgrc_cordic.sv
module pgrc_cordic
    import pgrc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic signed [CorW-1:0]  i_x,
    input  logic signed [CorW-1:0]  i_y,
    output logic                    o_vld,
    output logic [YawW-1:0]         o_yaw
);

    logic signed [CorW-1:0] r_x [0:Steps];
    logic signed [CorW-1:0] r_y [0:Steps];
    logic signed [AngW-1:0] r_z [0:Steps];
    logic [Steps:0]         r_v, r_zy, r_neg;
    logic [YawW-1:0]        r_yaw;
    logic                   r_ov;
    logic [AngW-1:0]        n_am;
    logic [AngW-1:0]        n_rd;

    always_ff @(posedge i_clk) begin
        r_zy[0]  <= (i_y == '0);
        r_neg[0] <= i_x[CorW-1];
        if (i_x[CorW-1] && i_y > 0) begin
            r_x[0] <= i_y;
            r_y[0] <= -i_x;
            r_z[0] <= HalfPi;
        end else if (i_x[CorW-1]) begin
            r_x[0] <= -i_y;
            r_y[0] <= i_x;
            r_z[0] <= -HalfPi;
        end else begin
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_z[0] <= '0;
        end
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_vld;
        end
    end

    for (genvar i = 0; i < Steps; i++) begin : g_it
        always_ff @(posedge i_clk) begin
            if (r_y[i] > 0) begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + atan_lut(i);
            end else begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - atan_lut(i);
            end
            r_zy[i+1]  <= r_zy[i];
            r_neg[i+1] <= r_neg[i];
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
        end
    end

    assign n_am = r_z[Steps][AngW-1] ? AngW'(-r_z[Steps]) : AngW'(r_z[Steps]);
    assign n_rd = (n_am + AngW'(1024)) >> 11;

    always_ff @(posedge i_clk) begin
        if (r_zy[Steps]) begin
            r_yaw <= r_neg[Steps] ? YawMax : '0;
        end else if (n_rd > AngW'(YawMax)) begin
            r_yaw <= YawMax;
        end else begin
            r_yaw <= n_rd[YawW-1:0];
        end
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[Steps];
        end
    end

    assign o_vld = r_ov;
    assign o_yaw = r_yaw;

endmodule
